@@ rtl/core/eps_pkg.sv @@
// eps_pkg: shared types and constants of the encoder period speed meter
// no dependencies; imported by every module of the block
package eps_pkg;

	localparam int unsigned SPEED_W = 15;
	localparam int unsigned WHOLE_W = 8;
	localparam int unsigned PERIOD_OUT_W = 16;
	localparam int unsigned RPM_W = 32;
	localparam int unsigned DIV_STEPS = RPM_W;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [RPM_W-1:0] RPM_CONSTANT_RESET = 32'd10000000;
	localparam logic [SPEED_W-1:0] SPEED_MAX = 15'h7FFF;

	typedef struct packed {
		logic tick;
		logic edge_req;
	} in_item_t;

	typedef struct packed {
		logic [SPEED_W-1:0] speed_q;
		logic [WHOLE_W-1:0] speed_whole;
		logic [PERIOD_OUT_W-1:0] period_ticks;
	} out_item_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} back_state_t;

endpackage

@@ rtl/core/encoder_period_speed_meter.sv @@
// Encoder period speed meter. Every accepted item gives one result. Items
// without an encoder edge, or with an edge at a zero count, pass the job queue
// and the result register at one per cycle while the divider is idle and the
// result is popped or absent. An edge with a nonzero count starts a restoring
// divider of rpm_constant by the period, one quotient bit per cycle, while a
// four-entry job queue absorbs arriving ticks before full is raised. A write to
// rpm_constant acts from the next edge on; the held speed is not recomputed.
// depends on eps_pkg, eps_front, eps_queue, eps_back
module encoder_period_speed_meter import eps_pkg::*; #(
	parameter int unsigned COUNTER_WIDTH = 16,
	parameter int unsigned FRACTION_BITS = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [RPM_W-1:0] cfg_wr_data,
	input  logic             push,
	output logic             full,
	input  in_item_t         in_item,
	output logic             empty,
	input  logic             pop,
	output out_item_t        out_item
);

	localparam int unsigned JOB_W = COUNTER_WIDTH + 1;

	logic                     accept;
	logic                     job_push;
	logic                     job_edge;
	logic [COUNTER_WIDTH-1:0] job_period;
	logic [JOB_W-1:0]         job_wdata;
	logic [JOB_W-1:0]         job_rdata;
	logic                     job_pop;
	logic                     job_empty;
	logic                     out_pop;

	assign accept = push && !full;
	assign out_pop = pop && !empty;
	assign job_wdata = {job_edge, job_period};

	eps_front #(
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (in_item),
		.job_push   (job_push),
		.job_edge   (job_edge),
		.job_period (job_period)
	);

	eps_queue #(
		.WIDTH(JOB_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_wdata),
		.full   (full),
		.pop    (job_pop),
		.rdata  (job_rdata),
		.empty  (job_empty)
	);

	eps_back #(
		.COUNTER_WIDTH(COUNTER_WIDTH),
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.job_empty   (job_empty),
		.job_edge    (job_rdata[JOB_W-1]),
		.job_period  (job_rdata[COUNTER_WIDTH-1:0]),
		.job_pop     (job_pop),
		.empty       (empty),
		.pop         (out_pop),
		.item        (out_item)
	);

endmodule

@@ rtl/core/eps_front.sv @@
// eps_front: tick counter and edge classification of incoming items
// depends on eps_pkg; feeds jobs {edge, period} into the job queue
module eps_front import eps_pkg::*; #(
	parameter int unsigned COUNTER_WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  in_item_t                 item,
	output logic                     job_push,
	output logic                     job_edge,
	output logic [COUNTER_WIDTH-1:0] job_period
);

	logic [COUNTER_WIDTH-1:0] tick_count_q;
	logic [COUNTER_WIDTH-1:0] count_base;

	// edge clears the counter before the tick is applied
	assign count_base = item.edge_req ? '0 : tick_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
		end else if (accept) begin
			tick_count_q <= count_base + COUNTER_WIDTH'(item.tick);
		end
	end

	assign job_push = accept;
	assign job_edge = item.edge_req;
	assign job_period = tick_count_q;

endmodule

@@ rtl/core/eps_queue.sv @@
// eps_queue: short job queue between the front and the divider back end
// depends on eps_pkg only by convention; generic width, four entries
module eps_queue import eps_pkg::*; #(
	parameter int unsigned WIDTH = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int unsigned DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(DEPTH);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full = (count_q == (PTR_W+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/eps_back.sv @@
// eps_back: speed computation with a bit-serial divider and the result register
// depends on eps_pkg; takes jobs from eps_queue, holds rpm_constant
module eps_back import eps_pkg::*; #(
	parameter int unsigned COUNTER_WIDTH = 16,
	parameter int unsigned FRACTION_BITS = 7
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [RPM_W-1:0]         cfg_wr_data,
	input  logic                     job_empty,
	input  logic                     job_edge,
	input  logic [COUNTER_WIDTH-1:0] job_period,
	output logic                     job_pop,
	output logic                     empty,
	input  logic                     pop,
	output out_item_t                item
);

	back_state_t              state_q;
	back_state_t              state_nxt;
	logic [RPM_W-1:0]         rpm_constant_q;
	logic [COUNTER_WIDTH-1:0] period_q;
	logic [SPEED_W-1:0]       speed_held_q;
	logic [DIV_CNT_W-1:0]     div_cnt_q;
	logic [COUNTER_WIDTH-1:0] rem_q;
	logic [RPM_W-1:0]         dq_q;
	logic                     out_valid_q;
	out_item_t                out_q;

	logic                     slot_free;
	logic                     div_job;
	logic                     start_div;
	logic                     load_out;
	logic [SPEED_W-1:0]       nxt_speed;
	logic [COUNTER_WIDTH-1:0] nxt_period;
	logic [COUNTER_WIDTH:0]   rem_shift;
	logic [COUNTER_WIDTH:0]   rem_sub;
	logic                     rem_ge;
	logic [COUNTER_WIDTH-1:0] rem_next;
	logic [RPM_W-1:0]         quot_final;
	logic [SPEED_W-1:0]       quot_sat;
	logic [SPEED_W-1:0]       whole_shift;
	logic [RPM_W-1:0]         period_wide;

	assign slot_free = !out_valid_q || pop;
	assign div_job = job_edge && (job_period != '0);

	// one restoring step per cycle, quotient bits shift into the dividend register
	assign rem_shift = {rem_q, dq_q[RPM_W-1]};
	assign rem_sub = rem_shift - {1'b0, period_q};
	assign rem_ge = (rem_shift >= {1'b0, period_q});
	assign rem_next = rem_ge ? rem_sub[COUNTER_WIDTH-1:0] : rem_shift[COUNTER_WIDTH-1:0];
	assign quot_final = {dq_q[RPM_W-2:0], rem_ge};
	assign quot_sat = (|quot_final[RPM_W-1:SPEED_W]) ? SPEED_MAX : quot_final[SPEED_W-1:0];

	always_comb begin
		state_nxt = state_q;
		job_pop = 1'b0;
		start_div = 1'b0;
		load_out = 1'b0;
		nxt_speed = speed_held_q;
		nxt_period = period_q;
		case (state_q)
			BK_IDLE: begin
				if (!job_empty) begin
					if (div_job) begin
						job_pop = 1'b1;
						start_div = 1'b1;
						state_nxt = BK_DIV;
					end else if (slot_free) begin
						job_pop = 1'b1;
						load_out = 1'b1;
						// zero period gives zero speed
						if (job_edge) begin
							nxt_speed = '0;
							nxt_period = '0;
						end
					end
				end
			end
			BK_DIV: begin
				if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_nxt = BK_DONE;
				end
			end
			BK_DONE: begin
				if (slot_free) begin
					load_out = 1'b1;
					state_nxt = BK_IDLE;
				end
			end
			default: begin
				state_nxt = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			rpm_constant_q <= RPM_CONSTANT_RESET;
			period_q <= '0;
			speed_held_q <= '0;
			div_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr_en) begin
				rpm_constant_q <= cfg_wr_data;
			end
			if (start_div) begin
				period_q <= job_period;
				div_cnt_q <= '0;
			end else if (state_q == BK_DIV) begin
				div_cnt_q <= div_cnt_q + 1'b1;
				if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					speed_held_q <= quot_sat;
				end
			end else if (load_out) begin
				period_q <= nxt_period;
				speed_held_q <= nxt_speed;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_div) begin
			rem_q <= '0;
			dq_q <= rpm_constant_q;
		end else if (state_q == BK_DIV) begin
			rem_q <= rem_next;
			dq_q <= quot_final;
		end
	end

	assign whole_shift = nxt_speed >> FRACTION_BITS;
	assign period_wide = RPM_W'(nxt_period);

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.speed_q <= nxt_speed;
			out_q.speed_whole <= whole_shift[WHOLE_W-1:0];
			out_q.period_ticks <= period_wide[PERIOD_OUT_W-1:0];
		end
	end

	assign empty = !out_valid_q;
	assign item = out_q;

endmodule
